// File: rtl/sha_pkg.sv
package sha_pkg;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   // source of the byte shifted into the block register
   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         shift_byte;
      byte_sel_type byte_sel;
      logic         count_byte;
      logic         load_vars;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         update_hash;
      logic         init_hash;
      logic [2:0]   out_idx;
   } dp_cmd_type;

   localparam logic [7:0]  PAD_MARK      = 8'h80;
   localparam logic [5:0]  LEN_POS       = 6'd56;
   localparam logic [5:0]  LAST_POS      = 6'd63;
   localparam logic [5:0]  LAST_ROUND    = 6'd63;
   localparam logic [2:0]  LAST_WORD_IDX = 3'd7;
   localparam logic [63:0] BYTE_BITS     = 64'd8;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// File: rtl/sha_dp.sv
module sha_dp (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::dp_cmd_type cmd,
   input  logic [7:0]          data_byte,
   output logic [31:0]         digest_word
);

   logic [31:0]  hash_ff [8];
   logic [31:0]  hash_in [8];
   logic [31:0]  v_ff [8];
   logic [31:0]  v_in [8];
   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   logic [63:0]  bits_ff;
   logic [63:0]  bits_in;
   logic [7:0]   byte_mux;
   logic [31:0]  w_new;
   logic [31:0]  t1;
   logic [31:0]  t2;
   logic [31:0]  ch;
   logic [31:0]  maj;

   // byte source
   always_comb begin
      case (cmd.byte_sel)
         sha_pkg::SEL_DATA: byte_mux = data_byte;
         sha_pkg::SEL_MARK: byte_mux = sha_pkg::PAD_MARK;
         sha_pkg::SEL_ZERO: byte_mux = 8'h00;
         sha_pkg::SEL_LEN:  byte_mux = bits_ff[63:56];
         default:           byte_mux = 8'h00;
      endcase
   end

   // message schedule: word 0 sits at the top of the block register
   assign w_new = sha_pkg::small_sigma1(blk_ff[63:32]) + blk_ff[223:192]
                + sha_pkg::small_sigma0(blk_ff[479:448]) + blk_ff[511:480];

   always_comb begin
      if (cmd.shift_byte) begin
         blk_in = {blk_ff[503:0], byte_mux};
      end else if (cmd.round_en) begin
         blk_in = {blk_ff[479:0], w_new};
      end else begin
         blk_in = blk_ff;
      end
   end

   // one compression round
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + sha_pkg::big_sigma1(v_ff[4]) + ch
              + sha_pkg::ROUND_K[cmd.round_idx] + blk_ff[511:480];
   assign t2  = sha_pkg::big_sigma0(v_ff[0]) + maj;

   always_comb begin
      v_in = v_ff;
      if (cmd.load_vars) begin
         v_in = hash_ff;
      end else if (cmd.round_en) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_comb begin
      hash_in = hash_ff;
      if (cmd.init_hash) begin
         hash_in = sha_pkg::INIT_H;
      end else if (cmd.update_hash) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end
   end

   // bit count, shifted out msb first as the length field
   always_comb begin
      if (cmd.init_hash) begin
         bits_in = '0;
      end else if (cmd.count_byte) begin
         bits_in = bits_ff + sha_pkg::BYTE_BITS;
      end else if (cmd.shift_byte && cmd.byte_sel == sha_pkg::SEL_LEN) begin
         bits_in = {bits_ff[55:0], 8'h00};
      end else begin
         bits_in = bits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= sha_pkg::INIT_H;
         bits_ff <= '0;
      end else begin
         hash_ff <= hash_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
   end

   assign digest_word = hash_ff[cmd.out_idx];

endmodule

// File: rtl/sha_ctrl.sv
module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_byte_present,
   input  logic                req_message_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_word_number,
   output logic                rsp_last_word,
   output sha_pkg::dp_cmd_type cmd
);

   sha_pkg::state_type state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] word_ff, word_in;
   logic       end_ff, end_in;
   logic       mark_ff, mark_in;
   logic       len_blk_ff, len_blk_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_stall       = (state_ff != sha_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha_pkg::ST_OUT);
   assign req_xfer        = req_valid && !req_stall;
   assign rsp_xfer        = rsp_valid && !rsp_stall;
   assign rsp_word_number = word_ff;
   assign rsp_last_word   = (word_ff == sha_pkg::LAST_WORD_IDX);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      rnd_in     = rnd_ff;
      word_in    = word_ff;
      end_in     = end_ff;
      mark_in    = mark_ff;
      len_blk_in = len_blk_ff;

      cmd             = '0;
      cmd.byte_sel    = sha_pkg::SEL_DATA;
      cmd.round_idx   = rnd_ff;
      cmd.out_idx     = word_ff;

      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_byte_present) begin
                  cmd.shift_byte = 1'b1;
                  cmd.count_byte = 1'b1;
                  fill_in        = fill_ff + 6'd1;
               end
               if (req_byte_present && fill_ff == sha_pkg::LAST_POS) begin
                  cmd.load_vars = 1'b1;
                  rnd_in        = '0;
                  end_in        = req_message_end;
                  state_in      = sha_pkg::ST_ROUND;
               end else if (req_message_end) begin
                  end_in   = 1'b1;
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == sha_pkg::LAST_ROUND) begin
               state_in = sha_pkg::ST_UPDATE;
            end
         end
         sha_pkg::ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            if (!end_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (mark_ff && len_blk_ff) begin
               state_in = sha_pkg::ST_OUT;
            end else begin
               // message end, but the closing block left no room for the length: pad another
               if (mark_ff) begin
                  len_blk_in = 1'b1;
               end
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_PAD: begin
            cmd.shift_byte = 1'b1;
            fill_in        = fill_ff + 6'd1;
            if (!mark_ff) begin
               cmd.byte_sel = sha_pkg::SEL_MARK;
               mark_in      = 1'b1;
               len_blk_in   = (fill_ff < sha_pkg::LEN_POS);
            end else if (fill_ff >= sha_pkg::LEN_POS && len_blk_ff) begin
               cmd.byte_sel = sha_pkg::SEL_LEN;
            end else begin
               cmd.byte_sel = sha_pkg::SEL_ZERO;
            end
            if (fill_ff == sha_pkg::LAST_POS) begin
               cmd.load_vars = 1'b1;
               rnd_in        = '0;
               state_in      = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_OUT: begin
            if (rsp_xfer) begin
               word_in = word_ff + 3'd1;
               if (word_ff == sha_pkg::LAST_WORD_IDX) begin
                  cmd.init_hash = 1'b1;
                  fill_in       = '0;
                  end_in        = 1'b0;
                  mark_in       = 1'b0;
                  len_blk_in    = 1'b0;
                  state_in      = sha_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha_pkg::ST_IDLE;
         fill_ff    <= '0;
         rnd_ff     <= '0;
         word_ff    <= '0;
         end_ff     <= 1'b0;
         mark_ff    <= 1'b0;
         len_blk_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         rnd_ff     <= rnd_in;
         word_ff    <= word_in;
         end_ff     <= end_in;
         mark_ff    <= mark_in;
         len_blk_ff <= len_blk_in;
      end
   end

endmodule

// File: rtl/sha256_hash_engine_core.sv
// a byte that does not fill the block is taken while idle; the byte that fills 64
//   starts 64 rounds and an update, with req_stall held high until they are done
// message end: one pad byte per cycle up to byte 63, then 64 rounds + 1 update for
//   each of one or two padded blocks, then 8 digest transfers, one per unstalled cycle
// the single round unit (one sha-256 round per cycle) sets the throughput
// reset: synchronous, active high; chaining words go to the initial hash values
module sha256_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   // message byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   // digest word channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);

   // command bundle from the sequencer into the round datapath
   sha_pkg::dp_cmd_type cmd;

   // controller: byte fill count, padding sequence, round and word counters;
   // it takes a transfer only when idle and holds req_stall high otherwise
   sha_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_number  (rsp_word_number),
      .rsp_last_word    (rsp_last_word),
      .cmd              (cmd)
   );

   // datapath: 512-bit block shift register that doubles as the schedule
   // window, working variables a..h, chaining words and the bit counter
   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .digest_word (rsp_digest_word)
   );

endmodule

// File: rtl/sha_chk.sv
module sha_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_number,
   input logic        rsp_last_word
);

   // no byte is taken while digest words are going out
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during digest output");

   // stalled digest word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_number))
      else $error("digest word changed under stall");

   // words follow one another in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
         rsp_valid && rsp_word_number == 3'($past(rsp_word_number) + 3'd1))
      else $error("digest word out of order");

   // run ends after the last word
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid)
      else $error("output continued past last word");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_word == (rsp_word_number == sha_pkg::LAST_WORD_IDX))
      else $error("last word flag mismatch");

endmodule

bind sha256_hash_engine_core sha_chk u_sha_chk (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_number (rsp_word_number),
   .rsp_last_word   (rsp_last_word)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // run limits: watchdog bound, number of random transfers and drain time after the last digest
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 420;
   localparam int DRAIN_CYCLES = 200;

   // well-known digests that can be typed in directly
   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   // round constants and initial chaining value, kept apart from the rtl package
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // one row of the directed table; known rows carry a typed-in digest
   typedef struct packed {
      logic [7:0]   data;
      logic         present;
      logic         msg_end;
      logic         known;
      logic [255:0] digest;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_message_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_number;
   logic        rsp_last_word;

   // predictor state: chaining value, partial block, fill count, bits already hashed
   logic [31:0] chain_h [8];
   logic [7:0]  blk_bytes [64];
   int          blk_count;
   logic [63:0] bits_done;

   digest_word_type digest_words_due [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;

   sha256_hash_engine_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_word_number  (rsp_word_number),
      .rsp_last_word    (rsp_last_word)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_hash_engine_core test failed");
         $finish;
      end
   end

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // start a new message: initial chaining value, empty block, zero length
   function automatic void restart_message();
      for (int j = 0; j < 8; j++) chain_h[j] = SHA_H0[j];
      blk_count = 0;
      bits_done = '0;
   endfunction

   // one 64-round compression of blk_bytes into chain_h
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   // absorb one transfer; returns 1 with the finished digest on a message end
   function automatic bit absorb_byte(input logic [7:0] data, input logic present,
                                      input logic msg_end, output logic [255:0] digest);
      logic [63:0] total;
      int          pos;
      digest = '0;
      if (present) begin
         blk_bytes[blk_count] = data;
         blk_count++;
         if (blk_count == 64) begin
            compress_block();
            bits_done += 64'd512;
            blk_count = 0;
         end
      end
      if (!msg_end) return 1'b0;
      total = bits_done + 64'(blk_count) * 64'd8;
      blk_bytes[blk_count] = 8'h80;
      pos = blk_count + 1;
      // no room left for the length: flush a block of pad first
      if (pos > 56) begin
         for (int i = pos; i < 64; i++) blk_bytes[i] = 8'h00;
         compress_block();
         pos = 0;
      end
      for (int i = pos; i < 56; i++) blk_bytes[i] = 8'h00;
      for (int j = 0; j < 8; j++) blk_bytes[63-j] = total[8*j +: 8];
      compress_block();
      for (int j = 0; j < 8; j++) digest[255-32*j -: 32] = chain_h[j];
      restart_message();
      return 1'b1;
   endfunction

   // one transfer on the message byte channel, called at a falling edge;
   // the sender runs in bursts and drops valid for a random gap between them
   task automatic send_byte(input logic [7:0] data, input logic present,
                            input logic msg_end, input logic known,
                            input logic [255:0] typed_digest);
      logic [255:0]    digest;
      digest_word_type dw;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_byte_present <= present;
      req_message_end  <= msg_end;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge
      if (absorb_byte(data, present, msg_end, digest)) begin
         if (known) digest = typed_digest;
         for (int j = 0; j < 8; j++) begin
            dw.word  = digest[255-32*j -: 32];
            dw.index = 3'(j);
            dw.last  = (j == 7);
            digest_words_due.push_back(dw);
         end
      end
      @(negedge clock);
   endtask

   // receiver back-pressure: a mode is held for a random stretch, then changes
   int stall_mode = 0;
   int stall_left = 0;
   int stall_tick = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;                                  // free flow
         1: rsp_stall <= ($urandom_range(0, 3) == 0);           // light
         2: rsp_stall <= ($urandom_range(0, 3) != 0);           // heavy
         default: rsp_stall <= stall_tick[2];                   // square wave
      endcase
   end

   // digest word checker
   always @(posedge clock) begin
      digest_word_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_words_due.size() == 0) begin
            $error("unexpected digest word %h at word_number %0d",
                   rsp_digest_word, rsp_word_number);
            error_count++;
         end else begin
            due = digest_words_due.pop_front();
            if (rsp_digest_word !== due.word) begin
               $error("digest_word: expected %h, got %h", due.word, rsp_digest_word);
               error_count++;
            end
            if (rsp_word_number !== due.index) begin
               $error("word_number: expected %0d, got %0d", due.index, rsp_word_number);
               error_count++;
            end
            if (rsp_last_word !== due.last) begin
               $error("last_word: expected %0b, got %0b", due.last, rsp_last_word);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type stim_rows [13];
      int           items_sent;
      int           msg_len;
      int           pick;
      bit           end_on_byte;

      stim_rows = '{
         // empty message straight out of reset
         '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
         // "abc", the standard short vector
         '{8'h61, 1'b1, 1'b0, 1'b0, '0},
         '{8'h62, 1'b1, 1'b0, 1'b0, '0},
         '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
         // idle transfer between messages
         '{8'hff, 1'b0, 1'b0, 1'b0, '0},
         // idle in the middle of a message, end carried on a byte
         '{8'h00, 1'b1, 1'b0, 1'b0, '0},
         '{8'hff, 1'b0, 1'b0, 1'b0, '0},
         '{8'hff, 1'b1, 1'b1, 1'b0, '0},
         // empty message with a byte that is not part of it
         '{8'h55, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
         // end marked by a transfer with no byte
         '{8'hff, 1'b1, 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b0, 1'b0, '0},
         '{8'h80, 1'b0, 1'b1, 1'b0, '0},
         // one-byte message
         '{8'haa, 1'b1, 1'b1, 1'b0, '0}
      };

      for (int j = 0; j < 64; j++) blk_bytes[j] = 8'h00;
      restart_message();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[r])
         send_byte(stim_rows[r].data, stim_rows[r].present, stim_rows[r].msg_end,
                   stim_rows[r].known, stim_rows[r].digest);

      // random messages, weighted toward the pad boundaries at 55/56 and 63/64
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)
            msg_len = $urandom_range(0, 8);
         else if (pick < 7)
            msg_len = 64 * $urandom_range(0, 1) + $urandom_range(55, 64);
         else
            msg_len = $urandom_range(0, 200);
         end_on_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
         for (int k = 0; k < msg_len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
               items_sent++;
            end
            send_byte(8'($urandom_range(0, 255)), 1'b1,
                      end_on_byte && (k == msg_len - 1), 1'b0, '0);
            items_sent++;
         end
         if (!end_on_byte) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            items_sent++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding digests, then let the engine settle
      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("sha256_hash_engine_core test passed");
      else
         $display("sha256_hash_engine_core test failed");
      $finish;
   end

endmodule
